// ----- rtl/demarker_oscillator_zones_unit_defines.svh -----
// ----------------------------------------------------------------------------
// DeMarker zones unit: assertion macros
// Shared property forms for the checker of the oscillator block.
// ----------------------------------------------------------------------------
`ifndef DEMARKER_OSCILLATOR_ZONES_UNIT_DEFINES_SVH
`define DEMARKER_OSCILLATOR_ZONES_UNIT_DEFINES_SVH

// same-cycle implication
`define DOZ_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DOZ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/doz_pkg.sv -----
// ----------------------------------------------------------------------------
// DeMarker zones package
// Widths, constants, register indexes and the sequencer state type.
// ----------------------------------------------------------------------------
package doz_pkg;

  // price word and default sizes
  localparam int PRICE_BITS       = 32;
  localparam int PERIOD_MAX_DEF   = 64;
  localparam int LOOKBACK_MAX_DEF = 8;

  // result fields
  localparam int IND_W  = 14;
  localparam int FLAG_W = 2;
  localparam logic [IND_W-1:0] SCALE = 14'd10000;

  // run counters
  localparam int RUN_W = 16;
  localparam logic [RUN_W-1:0] RUN_MAX = 16'hFFFF;

  // register field widths
  localparam int WP_W  = 7;
  localparam int LB_W  = 4;
  localparam int LVL_W = 14;
  localparam int DUR_W = 16;

  // configuration port
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  localparam logic [2:0] REG_WINDOW_PERIOD    = 3'd0;
  localparam logic [2:0] REG_HIGH_LOOKBACK    = 3'd1;
  localparam logic [2:0] REG_LOW_LOOKBACK     = 3'd2;
  localparam logic [2:0] REG_OVERBOUGHT_LEVEL = 3'd3;
  localparam logic [2:0] REG_OVERSOLD_LEVEL   = 3'd4;
  localparam logic [2:0] REG_ZONE_DURATION    = 3'd5;
  localparam logic [2:0] REG_DURATION_ENABLE  = 3'd6;

  // register reset values
  localparam logic [WP_W-1:0]  RST_WINDOW_PERIOD = 7'd14;
  localparam logic [LB_W-1:0]  RST_LOOKBACK      = 4'd1;
  localparam logic [LVL_W-1:0] RST_OVERBOUGHT    = 14'd7000;
  localparam logic [LVL_W-1:0] RST_OVERSOLD      = 14'd3000;
  localparam logic [DUR_W-1:0] RST_DURATION      = 16'd6;

  // zone flag codes
  localparam logic [FLAG_W-1:0] ZONE_NONE  = 2'd0;
  localparam logic [FLAG_W-1:0] ZONE_OVER  = 2'd1;
  localparam logic [FLAG_W-1:0] ZONE_UNDER = 2'd2;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOVE,
    ST_SUM,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } doz_state_t;

endpackage

// ----- rtl/doz_bar_if.sv -----
// ----------------------------------------------------------------------------
// DeMarker zones bar channel
// Valid/ready channel carrying one price bar per word.
// ----------------------------------------------------------------------------
interface doz_bar_if;
  logic                           valid;
  logic                           ready;
  logic [doz_pkg::PRICE_BITS-1:0] bar_high;
  logic [doz_pkg::PRICE_BITS-1:0] bar_low;

  modport source (output valid, output bar_high, output bar_low, input ready);
  modport sink   (input valid, input bar_high, input bar_low, output ready);
endinterface

// ----- rtl/doz_res_if.sv -----
// ----------------------------------------------------------------------------
// DeMarker zones result channel
// Valid/ready channel carrying one oscillator result per word.
// ----------------------------------------------------------------------------
interface doz_res_if;
  logic                         valid;
  logic                         ready;
  logic [doz_pkg::IND_W-1:0]    indicator;
  logic                         indicator_valid;
  logic [doz_pkg::FLAG_W-1:0]   zone_flag;

  modport source (output valid, output indicator, output indicator_valid,
                  output zone_flag, input ready);
  modport sink   (input valid, input indicator, input indicator_valid,
                  input zone_flag, output ready);
endinterface

// ----- rtl/doz_ram.sv -----
// ----------------------------------------------------------------------------
// DeMarker zones generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module doz_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/demarker_oscillator_zones_unit.sv -----
// ----------------------------------------------------------------------------
// DeMarker oscillator with zone shading
// Bar channel in, result channel out, APB-style register port.
// ----------------------------------------------------------------------------
// Usage:
//   bar    : one price bar (high, low) per word, taken when valid and ready.
//   result : one word per bar: indicator in basis points, indicator_valid,
//            zone_flag (none / overbought / oversold shading).
//   APB    : seven registers at byte address 4*index; the user writes them
//            only while the block is idle, which it does not enforce; reads
//            return the stored values.
// Timing: a bar passes through MOVE, SUM, MUL, DIV and FIN from acceptance
//   to a loaded result; during warm-up it goes from MOVE straight to FIN.
//   The window sum reads one stored move per cycle from the move RAM over the
//   active window period (1..PERIOD_MAX), then a restoring divider yields one
//   quotient bit per cycle. One bar is in flight at a time; ready is high
//   only while idle, so a new bar is taken only once the last is done.
// Stall: the result sits in an output register; a new bar is accepted while
//   it waits, and the next result holds back until the old one is taken.
// Reset: synchronous; registers return to defaults, bar count and run counts
//   clear, the output register empties. No clearing pass is needed.
module demarker_oscillator_zones_unit #(
  parameter int PERIOD_MAX   = doz_pkg::PERIOD_MAX_DEF,
  parameter int LOOKBACK_MAX = doz_pkg::LOOKBACK_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  doz_bar_if.sink                         bar,
  doz_res_if.source                       result,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [doz_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [doz_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [doz_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);

  localparam int PB       = doz_pkg::PRICE_BITS;
  localparam int IW       = doz_pkg::IND_W;
  localparam int RW       = doz_pkg::RUN_W;
  localparam int PTR_W    = $clog2(PERIOD_MAX);
  localparam int CNT_W    = $clog2(PERIOD_MAX + 1);
  localparam int LB_IDX_W = (LOOKBACK_MAX > 1) ? $clog2(LOOKBACK_MAX) : 1;
  localparam int LB_CNT_W = $clog2(LOOKBACK_MAX + 1);
  localparam int SUM_W    = PB + $clog2(PERIOD_MAX);
  localparam int TOT_W    = SUM_W + 1;
  localparam int NUM_W    = SUM_W + IW;
  localparam int REM_W    = TOT_W + 1;
  localparam int STEP_W   = $clog2(IW);

  // configuration registers
  logic [doz_pkg::WP_W-1:0]  cfg_period;
  logic [doz_pkg::LB_W-1:0]  cfg_hlb;
  logic [doz_pkg::LB_W-1:0]  cfg_llb;
  logic [doz_pkg::LVL_W-1:0] cfg_ob;
  logic [doz_pkg::LVL_W-1:0] cfg_os;
  logic [doz_pkg::DUR_W-1:0] cfg_dur;
  logic                      cfg_den;

  // sequencer
  doz_pkg::doz_state_t state, state_next;

  // datapath state
  logic [PB-1:0]    bar_hi, bar_lo;
  logic [PB-1:0]    hist_hi [LOOKBACK_MAX];
  logic [PB-1:0]    hist_lo [LOOKBACK_MAX];
  logic [RW-1:0]    bars_seen, over_run, under_run;
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] issue_cnt;
  logic             acc_v;
  logic             warm_ok;
  logic [SUM_W-1:0] up_sum, dn_sum;
  logic [TOT_W-1:0] total;
  logic [TOT_W-1:0] rem;
  logic [IW-1:0]    num_lo;
  logic [IW-1:0]    quo;
  logic [STEP_W-1:0] step;

  // output register
  logic                       out_v;
  logic [IW-1:0]              out_ind;
  logic                       out_iv;
  logic [doz_pkg::FLAG_W-1:0] out_flag;

  // control strobes
  logic cfg_wr;
  logic ram_we, ram_re, fin_go, in_take;

  // combinational values
  logic [CNT_W-1:0]    per;
  logic [LB_CNT_W-1:0] hlb, llb;
  logic [LB_IDX_W-1:0] hidx, lidx;
  logic [doz_pkg::DUR_W-1:0] dur;
  logic [PB-1:0]       past_hi, past_lo, up_mv, dn_mv;
  logic                warm_c;
  logic [PTR_W-1:0]    wr_ptr_inc, rd_ptr_dec;
  logic [2*PB-1:0]     ram_rdata;
  logic [NUM_W-1:0]    prod;
  logic [REM_W-1:0]    rem2;
  logic                div_ge;
  logic                fin_valid;
  logic [IW-1:0]       fin_ind;
  logic [RW-1:0]       over_next, under_next;
  logic [doz_pkg::FLAG_W-1:0] flag_c;

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_period <= doz_pkg::RST_WINDOW_PERIOD;
      cfg_hlb    <= doz_pkg::RST_LOOKBACK;
      cfg_llb    <= doz_pkg::RST_LOOKBACK;
      cfg_ob     <= doz_pkg::RST_OVERBOUGHT;
      cfg_os     <= doz_pkg::RST_OVERSOLD;
      cfg_dur    <= doz_pkg::RST_DURATION;
      cfg_den    <= 1'b1;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        doz_pkg::REG_WINDOW_PERIOD:    cfg_period <= pwdata[doz_pkg::WP_W-1:0];
        doz_pkg::REG_HIGH_LOOKBACK:    cfg_hlb    <= pwdata[doz_pkg::LB_W-1:0];
        doz_pkg::REG_LOW_LOOKBACK:     cfg_llb    <= pwdata[doz_pkg::LB_W-1:0];
        doz_pkg::REG_OVERBOUGHT_LEVEL: cfg_ob     <= pwdata[doz_pkg::LVL_W-1:0];
        doz_pkg::REG_OVERSOLD_LEVEL:   cfg_os     <= pwdata[doz_pkg::LVL_W-1:0];
        doz_pkg::REG_ZONE_DURATION:    cfg_dur    <= pwdata[doz_pkg::DUR_W-1:0];
        doz_pkg::REG_DURATION_ENABLE:  cfg_den    <= pwdata[0];
        default: ;
      endcase
    end
  end

  // read-back mux
  always_comb begin
    unique case (paddr[4:2])
      doz_pkg::REG_WINDOW_PERIOD:    prdata = 32'(cfg_period);
      doz_pkg::REG_HIGH_LOOKBACK:    prdata = 32'(cfg_hlb);
      doz_pkg::REG_LOW_LOOKBACK:     prdata = 32'(cfg_llb);
      doz_pkg::REG_OVERBOUGHT_LEVEL: prdata = 32'(cfg_ob);
      doz_pkg::REG_OVERSOLD_LEVEL:   prdata = 32'(cfg_os);
      doz_pkg::REG_ZONE_DURATION:    prdata = 32'(cfg_dur);
      doz_pkg::REG_DURATION_ENABLE:  prdata = 32'(cfg_den);
      default:                       prdata = '0;
    endcase
  end

  // clamp period, lookbacks and duration into their usable ranges
  always_comb begin
    if (cfg_period == '0) begin
      per = CNT_W'(1);
    end else if (32'(cfg_period) > PERIOD_MAX) begin
      per = CNT_W'(PERIOD_MAX);
    end else begin
      per = CNT_W'(cfg_period);
    end
    if (cfg_hlb == '0) begin
      hlb = LB_CNT_W'(1);
    end else if (32'(cfg_hlb) > LOOKBACK_MAX) begin
      hlb = LB_CNT_W'(LOOKBACK_MAX);
    end else begin
      hlb = LB_CNT_W'(cfg_hlb);
    end
    if (cfg_llb == '0) begin
      llb = LB_CNT_W'(1);
    end else if (32'(cfg_llb) > LOOKBACK_MAX) begin
      llb = LB_CNT_W'(LOOKBACK_MAX);
    end else begin
      llb = LB_CNT_W'(cfg_llb);
    end
    dur = (cfg_dur == '0) ? doz_pkg::DUR_W'(1) : cfg_dur;
  end

  assign hidx = LB_IDX_W'(hlb - LB_CNT_W'(1));
  assign lidx = LB_IDX_W'(llb - LB_CNT_W'(1));

  // up and down moves; zero until the lookback bar exists
  assign past_hi = hist_hi[hidx];
  assign past_lo = hist_lo[lidx];

  always_comb begin
    up_mv = '0;
    dn_mv = '0;
    if ((bars_seen >= RW'(hlb)) && (bar_hi > past_hi)) begin
      up_mv = bar_hi - past_hi;
    end
    if ((bars_seen >= RW'(llb)) && (past_lo > bar_lo)) begin
      dn_mv = past_lo - bar_lo;
    end
  end

  assign warm_c = (bars_seen >= RW'(per));

  // circular pointers into the move RAM
  assign wr_ptr_inc = (wr_ptr == PTR_W'(PERIOD_MAX - 1)) ? '0 : wr_ptr + PTR_W'(1);
  assign rd_ptr_dec = (rd_ptr == '0) ? PTR_W'(PERIOD_MAX - 1) : rd_ptr - PTR_W'(1);

  // move store: {up, down} per bar, newest at wr_ptr
  doz_ram #(
    .WIDTH (2 * PB),
    .DEPTH (PERIOD_MAX)
  ) u_move_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ptr_inc),
    .wdata ({up_mv, dn_mv}),
    .re    (ram_re),
    .raddr (rd_ptr),
    .rdata (ram_rdata)
  );

  // scale and divider step
  assign prod   = NUM_W'(up_sum) * NUM_W'(doz_pkg::SCALE);
  assign rem2   = {rem, num_lo[IW-1]};
  assign div_ge = (rem2 >= REM_W'(total));

  // result and run counters
  assign fin_valid = warm_ok && (total != '0);
  assign fin_ind   = fin_valid ? quo : '0;

  always_comb begin
    over_next  = '0;
    under_next = '0;
    if (fin_valid) begin
      if (fin_ind >= cfg_ob) begin
        over_next = (over_run == doz_pkg::RUN_MAX) ? over_run : over_run + RW'(1);
      end else if (fin_ind <= cfg_os) begin
        under_next = (under_run == doz_pkg::RUN_MAX) ? under_run : under_run + RW'(1);
      end
    end
    flag_c = doz_pkg::ZONE_NONE;
    if (cfg_den) begin
      if (over_next >= dur) begin
        flag_c = doz_pkg::ZONE_OVER;
      end else if (under_next >= dur) begin
        flag_c = doz_pkg::ZONE_UNDER;
      end
    end
  end

  // sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      doz_pkg::ST_IDLE: if (bar.valid) state_next = doz_pkg::ST_MOVE;
      doz_pkg::ST_MOVE: state_next = warm_c ? doz_pkg::ST_SUM : doz_pkg::ST_FIN;
      doz_pkg::ST_SUM:  if (!ram_re && !acc_v) state_next = doz_pkg::ST_MUL;
      doz_pkg::ST_MUL:  state_next = doz_pkg::ST_DIV;
      doz_pkg::ST_DIV:  if (step == STEP_W'(IW - 1)) state_next = doz_pkg::ST_FIN;
      doz_pkg::ST_FIN:  if (fin_go) state_next = doz_pkg::ST_IDLE;
      default:          state_next = doz_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    bar.ready = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    fin_go    = 1'b0;
    unique case (state)
      doz_pkg::ST_IDLE: bar.ready = 1'b1;
      doz_pkg::ST_MOVE: ram_we = 1'b1;
      doz_pkg::ST_SUM:  ram_re = (issue_cnt < per);
      doz_pkg::ST_FIN:  fin_go = !out_v || result.ready;
      default: ;
    endcase
  end

  assign in_take = bar.valid && bar.ready;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= doz_pkg::ST_IDLE;
      bars_seen <= '0;
      over_run  <= '0;
      under_run <= '0;
      wr_ptr    <= '0;
      issue_cnt <= '0;
      acc_v     <= 1'b0;
      out_v     <= 1'b0;
    end else begin
      state <= state_next;
      if (ram_we) begin
        wr_ptr    <= wr_ptr_inc;
        bars_seen <= (bars_seen == doz_pkg::RUN_MAX) ? bars_seen : bars_seen + RW'(1);
        issue_cnt <= CNT_W'(1);
        acc_v     <= 1'b0;
      end else if (state == doz_pkg::ST_SUM) begin
        acc_v <= ram_re;
        if (ram_re) begin
          issue_cnt <= issue_cnt + CNT_W'(1);
        end
      end
      if (fin_go) begin
        over_run  <= over_next;
        under_run <= under_next;
        out_v     <= 1'b1;
      end else if (result.ready) begin
        out_v <= 1'b0;
      end
    end
  end

  // bar capture and history shift line
  always_ff @(posedge clk) begin
    if (in_take) begin
      bar_hi <= bar.bar_high;
      bar_lo <= bar.bar_low;
    end
    if (ram_we) begin
      for (int k = LOOKBACK_MAX - 1; k > 0; k--) begin
        hist_hi[k] <= hist_hi[k-1];
        hist_lo[k] <= hist_lo[k-1];
      end
      hist_hi[0] <= bar_hi;
      hist_lo[0] <= bar_lo;
    end
  end

  // window sums, scaling and serial divide
  always_ff @(posedge clk) begin
    unique case (state)
      doz_pkg::ST_MOVE: begin
        up_sum  <= SUM_W'(up_mv);
        dn_sum  <= SUM_W'(dn_mv);
        rd_ptr  <= wr_ptr;
        warm_ok <= warm_c;
      end
      doz_pkg::ST_SUM: begin
        if (ram_re) begin
          rd_ptr <= rd_ptr_dec;
        end
        if (acc_v) begin
          up_sum <= up_sum + SUM_W'(ram_rdata[2*PB-1:PB]);
          dn_sum <= dn_sum + SUM_W'(ram_rdata[PB-1:0]);
        end
      end
      doz_pkg::ST_MUL: begin
        total  <= TOT_W'(up_sum) + TOT_W'(dn_sum);
        rem    <= TOT_W'(prod[NUM_W-1:IW]);
        num_lo <= prod[IW-1:0];
        quo    <= '0;
        step   <= '0;
      end
      doz_pkg::ST_DIV: begin
        rem    <= div_ge ? TOT_W'(rem2 - REM_W'(total)) : TOT_W'(rem2);
        quo    <= {quo[IW-2:0], div_ge};
        num_lo <= {num_lo[IW-2:0], 1'b0};
        step   <= step + STEP_W'(1);
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_ind  <= fin_ind;
      out_iv   <= fin_valid;
      out_flag <= flag_c;
    end
  end

  assign result.valid           = out_v;
  assign result.indicator       = out_ind;
  assign result.indicator_valid = out_iv;
  assign result.zone_flag       = out_flag;

endmodule

// ----- rtl/doz_checker.sv -----
// ----------------------------------------------------------------------------
// DeMarker zones port checker
// Watches the channel ports of the top level over time; bound to it below.
// ----------------------------------------------------------------------------
`include "demarker_oscillator_zones_unit_defines.svh"

module doz_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [doz_pkg::IND_W-1:0] indicator,
  input logic                      indicator_valid
);

  // a stalled result word stays offered
  `DOZ_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid, "result dropped")

  // one bar at a time: busy right after a bar is taken
  `DOZ_ASSERT_NEXT(a_in_busy, clk, rst, in_valid && in_ready, !in_ready, "bar taken while busy")

  // an undefined indicator reads as zero
  `DOZ_ASSERT_SAME(a_ind_zero, clk, rst, out_valid && !indicator_valid, indicator == '0, "invalid indicator not zero")

  // indicator never exceeds full scale
  `DOZ_ASSERT_SAME(a_ind_range, clk, rst, out_valid, indicator <= doz_pkg::SCALE, "indicator above full scale")

endmodule

bind demarker_oscillator_zones_unit doz_checker u_doz_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (bar.valid),
  .in_ready        (bar.ready),
  .out_valid       (result.valid),
  .out_ready       (result.ready),
  .indicator       (result.indicator),
  .indicator_valid (result.indicator_valid)
);

// ----- dv/demarker_oscillator_zones_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DeMarker zones unit testbench
// Drives price bars and APB register writes into the oscillator block, and
// predicts every result word with a cycle-free model of the window sums,
// the ratio and the zone run counters. Results are checked in order as they
// are taken from the result channel. Both channels idle at random.
// ----------------------------------------------------------------------------
module demarker_oscillator_zones_unit_tb;
  import doz_pkg::*;

  localparam int CLK_HALF   = 2;
  localparam int STALL_MAX  = 9;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_WAIT = 100;
  localparam int PHASES     = 8;
  localparam int PHASE_BARS = 155;

  // one expected result word
  typedef struct packed {
    logic [IND_W-1:0]  indicator;
    logic              indicator_valid;
    logic [FLAG_W-1:0] zone_flag;
  } osc_word_t;

  // Predicts the oscillator words and keeps the ones not yet taken.
  class demarker_predictor;
    bit [WP_W-1:0]  period_reg;
    bit [LB_W-1:0]  high_lb_reg;
    bit [LB_W-1:0]  low_lb_reg;
    bit [LVL_W-1:0] over_level;
    bit [LVL_W-1:0] under_level;
    bit [DUR_W-1:0] duration_reg;
    bit             flag_enable;

    bit [PRICE_BITS-1:0] high_hist [LOOKBACK_MAX_DEF];
    bit [PRICE_BITS-1:0] low_hist [LOOKBACK_MAX_DEF];
    bit [PRICE_BITS-1:0] up_moves [PERIOD_MAX_DEF];
    bit [PRICE_BITS-1:0] down_moves [PERIOD_MAX_DEF];
    bit [RUN_W-1:0]      bars_taken;
    bit [RUN_W-1:0]      over_count;
    bit [RUN_W-1:0]      under_count;

    osc_word_t   expected_words[$];
    int unsigned mismatch_count;

    function new();
      period_reg   = RST_WINDOW_PERIOD;
      high_lb_reg  = RST_LOOKBACK;
      low_lb_reg   = RST_LOOKBACK;
      over_level   = RST_OVERBOUGHT;
      under_level  = RST_OVERSOLD;
      duration_reg = RST_DURATION;
      flag_enable  = 1'b1;
      foreach (high_hist[k]) begin
        high_hist[k] = '0;
        low_hist[k]  = '0;
      end
      foreach (up_moves[k]) begin
        up_moves[k]   = '0;
        down_moves[k] = '0;
      end
      bars_taken     = '0;
      over_count     = '0;
      under_count    = '0;
      mismatch_count = 0;
    endfunction

    // out-of-range settings fold onto 1..top
    function int unsigned clamp_to(int unsigned v, int unsigned top);
      if (v == 0) return 1;
      if (v > top) return top;
      return v;
    endfunction

    function void write_reg(logic [2:0] idx, bit [CFG_DATA_W-1:0] value);
      case (idx)
        REG_WINDOW_PERIOD:    period_reg   = value[WP_W-1:0];
        REG_HIGH_LOOKBACK:    high_lb_reg  = value[LB_W-1:0];
        REG_LOW_LOOKBACK:     low_lb_reg   = value[LB_W-1:0];
        REG_OVERBOUGHT_LEVEL: over_level   = value[LVL_W-1:0];
        REG_OVERSOLD_LEVEL:   under_level  = value[LVL_W-1:0];
        REG_ZONE_DURATION:    duration_reg = value[DUR_W-1:0];
        REG_DURATION_ENABLE:  flag_enable  = value[0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    // accepted bar: update history and windows, queue the expected word
    function void note_bar(bit [PRICE_BITS-1:0] hi, bit [PRICE_BITS-1:0] lo);
      int unsigned         span;
      int unsigned         hlb;
      int unsigned         llb;
      int unsigned         need;
      bit [PRICE_BITS-1:0] up_mv;
      bit [PRICE_BITS-1:0] down_mv;
      longint unsigned     up_total;
      longint unsigned     down_total;
      longint unsigned     ratio;
      osc_word_t           w;

      span = clamp_to(period_reg, PERIOD_MAX_DEF);
      hlb  = clamp_to(high_lb_reg, LOOKBACK_MAX_DEF);
      llb  = clamp_to(low_lb_reg, LOOKBACK_MAX_DEF);
      need = (duration_reg == 0) ? 1 : duration_reg;

      // moves against the earlier bars, zero while history is short
      up_mv   = '0;
      down_mv = '0;
      if (bars_taken >= hlb && hi > high_hist[hlb-1]) up_mv = hi - high_hist[hlb-1];
      if (bars_taken >= llb && low_hist[llb-1] > lo) down_mv = low_hist[llb-1] - lo;

      for (int k = LOOKBACK_MAX_DEF - 1; k > 0; k--) begin
        high_hist[k] = high_hist[k-1];
        low_hist[k]  = low_hist[k-1];
      end
      high_hist[0] = hi;
      low_hist[0]  = lo;

      for (int k = PERIOD_MAX_DEF - 1; k > 0; k--) begin
        up_moves[k]   = up_moves[k-1];
        down_moves[k] = down_moves[k-1];
      end
      up_moves[0]   = up_mv;
      down_moves[0] = down_mv;

      up_total   = 0;
      down_total = 0;
      for (int k = 0; k < span; k++) begin
        up_total   += up_moves[k];
        down_total += down_moves[k];
      end

      w.indicator_valid = (bars_taken >= span) && (up_total + down_total != 0);
      if (bars_taken != RUN_MAX) bars_taken++;

      w.indicator = '0;
      w.zone_flag = ZONE_NONE;
      if (w.indicator_valid) begin
        ratio = (up_total * 64'd10000) / (up_total + down_total);
        w.indicator = ratio[IND_W-1:0];
        if (ratio >= over_level) begin
          if (over_count != RUN_MAX) over_count++;
          under_count = '0;
        end else begin
          over_count = '0;
          if (ratio <= under_level) begin
            if (under_count != RUN_MAX) under_count++;
          end else begin
            under_count = '0;
          end
        end
      end else begin
        over_count  = '0;
        under_count = '0;
      end

      if (flag_enable) begin
        if (over_count >= need) w.zone_flag = ZONE_OVER;
        else if (under_count >= need) w.zone_flag = ZONE_UNDER;
      end
      expected_words = {expected_words, w};
    endfunction

    // taken result word against the oldest expectation
    function void check_word(logic [IND_W-1:0] ind, logic vld, logic [FLAG_W-1:0] zone);
      osc_word_t w;
      if (expected_words.size() == 0) begin
        $error("result word with no bar outstanding: indicator %0d", ind);
        mismatch_count++;
        return;
      end
      w = expected_words.pop_front();
      if (ind !== w.indicator) begin
        $error("indicator: expected %0d, got %0d", w.indicator, ind);
        mismatch_count++;
      end
      if (vld !== w.indicator_valid) begin
        $error("indicator_valid: expected %0d, got %0d", w.indicator_valid, vld);
        mismatch_count++;
      end
      if (zone !== w.zone_flag) begin
        $error("zone_flag: expected %0d, got %0d", w.zone_flag, zone);
        mismatch_count++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  doz_bar_if bar_ch ();
  doz_res_if res_ch ();

  demarker_predictor osc_model;

  // price walk state
  bit [PRICE_BITS-1:0] price_base;
  bit [PRICE_BITS-1:0] last_hi;
  bit [PRICE_BITS-1:0] last_lo;
  int                  drift;
  int                  seg_left;
  bit                  flat_seg;
  bit                  no_gaps;
  int unsigned         idle_cycles;

  demarker_oscillator_zones_unit uut (
    .clk     (clk),
    .rst     (rst),
    .bar     (bar_ch),
    .result  (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  function automatic int idle_draw();
    return no_gaps ? 0 : $urandom_range(0, STALL_MAX);
  endfunction

  // random bits above the field, the register keeps only the field
  function automatic bit [CFG_DATA_W-1:0] with_junk(bit [CFG_DATA_W-1:0] value, int width);
    bit [CFG_DATA_W-1:0] junk;
    junk = $urandom;
    return (junk << width) | value;
  endfunction

  // APB write: setup, access, then psel and penable drop; starts at a falling edge
  task automatic write_cfg(input logic [2:0] idx, input bit [CFG_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    osc_model.write_reg(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_settings(input int per, input int hlb, input int llb,
                                input int ob, input int os, input int dur, input int en);
    write_cfg(REG_WINDOW_PERIOD, with_junk(per, WP_W));
    write_cfg(REG_HIGH_LOOKBACK, with_junk(hlb, LB_W));
    write_cfg(REG_LOW_LOOKBACK, with_junk(llb, LB_W));
    write_cfg(REG_OVERBOUGHT_LEVEL, with_junk(ob, LVL_W));
    write_cfg(REG_OVERSOLD_LEVEL, with_junk(os, LVL_W));
    write_cfg(REG_ZONE_DURATION, with_junk(dur, DUR_W));
    write_cfg(REG_DURATION_ENABLE, with_junk(en, 1));
  endtask

  // one bar word; starts and ends at a falling edge
  task automatic send_bar(input bit [PRICE_BITS-1:0] hi, input bit [PRICE_BITS-1:0] lo);
    int gap;
    gap = idle_draw();
    if (gap > 0) begin
      bar_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    bar_ch.bar_high <= hi;
    bar_ch.bar_low  <= lo;
    bar_ch.valid    <= 1'b1;
    do @(posedge clk); while (!bar_ch.ready);
    @(negedge clk);
  endtask

  // lower valid and wait until every result word has been taken
  task automatic drain();
    bar_ch.valid <= 1'b0;
    do @(negedge clk); while (osc_model.pending() != 0);
  endtask

  // trending segments with random content, plus flat runs and noise bars
  task automatic run_bars(input int count);
    bit [PRICE_BITS-1:0] hi;
    bit [PRICE_BITS-1:0] lo;
    bit [PRICE_BITS-1:0] spread;
    int                  roll;
    for (int n = 0; n < count; n++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(4, 40);
        drift    = int'($urandom_range(0, 400)) - 200;
        flat_seg = ($urandom_range(0, 5) == 0);
        no_gaps  = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 9) == 0) price_base = $urandom;
      end
      seg_left--;
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        hi = $urandom;
        lo = $urandom;
      end else if (flat_seg) begin
        hi = last_hi;
        lo = last_lo;
      end else begin
        price_base = price_base + drift + $urandom_range(0, 20) - 10;
        spread     = $urandom_range(0, 50);
        hi         = price_base + spread;
        lo         = price_base - spread;
      end
      last_hi = hi;
      last_lo = lo;
      send_bar(hi, lo);
    end
  endtask

  // handshake monitors feed the predictor
  always @(posedge clk) begin
    if (!rst && bar_ch.valid && bar_ch.ready)
      osc_model.note_bar(bar_ch.bar_high, bar_ch.bar_low);
    if (!rst && res_ch.valid && res_ch.ready)
      osc_model.check_word(res_ch.indicator, res_ch.indicator_valid, res_ch.zone_flag);
  end

  // watchdog: cycles with no word moving on either channel
  always @(posedge clk) begin
    if (rst || (bar_ch.valid && bar_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // result side: random stalls before taking each word
  initial begin : result_sink
    int stall;
    res_ch.ready = 1'b0;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      stall = idle_draw();
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
      @(negedge clk);
    end
  end

  // main sequence
  initial begin : stimulus
    int per;
    int ob;
    int os;
    int dur;

    osc_model       = new();
    idle_cycles     = 0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    bar_ch.valid    = 1'b0;
    bar_ch.bar_high = '0;
    bar_ch.bar_low  = '0;
    price_base      = 32'd100000;
    last_hi         = '0;
    last_lo         = '0;
    drift           = 0;
    seg_left        = 0;
    flat_seg        = 1'b0;
    no_gaps         = 1'b0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: short window and runs so that both shadings show up
    apply_settings(2, 1, 2, 7000, 3000, 2, 1);
    // price extremes, the first ones while the lookback is still missing
    send_bar(32'h0000_0000, 32'h0000_0000);
    send_bar(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_bar(32'hFFFF_FFFF, 32'h0000_0000);
    send_bar(32'h0000_0000, 32'hFFFF_FFFF);
    send_bar(32'h0000_0000, 32'h0000_0000);
    // flat prices: zero window sum counts as warm-up
    repeat (4) send_bar(32'd1000, 32'd1000);
    // steady rise: overbought run reaches the duration
    for (int k = 1; k <= 5; k++) send_bar(32'd1000 + 100 * k, 32'd900 + 100 * k);
    // steady fall: oversold run reaches the duration
    for (int k = 1; k <= 5; k++) send_bar(32'd1500 - 100 * k, 32'd1400 - 100 * k);
    send_bar(32'h5555_5555, 32'hAAAA_AAAA);
    send_bar(32'hAAAA_AAAA, 32'h5555_5555);
    drain();

    // random phases, each under its own register setting
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: apply_settings(14, 1, 1, 7000, 3000, 6, 1);
        1: apply_settings(1, 8, 8, 10000, 0, 1, 1);
        2: apply_settings(64, 1, 8, 5000, 5000, 3, 1);
        3: apply_settings(0, 0, 15, 16383, 16383, 0, 1);
        4: apply_settings(127, 15, 0, 0, 0, 65535, 1);
        default: begin
          per = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 20) : $urandom_range(0, 127);
          ob  = ($urandom_range(0, 3) != 0) ? $urandom_range(5000, 10000)
                                            : $urandom_range(0, 16383);
          os  = $urandom_range(0, 5000);
          dur = ($urandom_range(0, 7) != 0) ? $urandom_range(0, 10) : $urandom_range(0, 65535);
          apply_settings(per, $urandom_range(0, 15), $urandom_range(0, 15), ob, os, dur,
                         (phase == 5) ? 0 : 1);
        end
      endcase
      run_bars(PHASE_BARS);
      drain();
    end

    repeat (DRAIN_WAIT) @(negedge clk);
    if (osc_model.mismatch_count == 0 && osc_model.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
